// File: design/spcol_pkg.sv
// ----------------------------------------------------------------------------
// spcol_pkg: shared constants for the shape pair collision block
// Pair mode codes, pipeline depth and default coordinate width.
// ----------------------------------------------------------------------------
package spcol_pkg;

   localparam int COORD_BITS_DEFAULT = 16;

   // register stages from req acceptance to rsp output register
   localparam int PIPE_DEPTH = 4;

   localparam logic [1:0] MODE_RR = 2'd0;   // rectangle with rectangle
   localparam logic [1:0] MODE_RC = 2'd1;   // rectangle with circle
   localparam logic [1:0] MODE_CC = 2'd2;   // circle with circle

endpackage

// File: design/shape_pair_collision_overlap.sv
// ----------------------------------------------------------------------------
// shape_pair_collision_overlap: rectangle/circle pair collision test
// Reports strict intersection and per-axis overlap for a pair of shapes.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one shape pair per item. Each shape is a rectangle
//   (left, top, width, height) or a circle (center, radius), in Q12.4.
//   req_tuser gives the two shape kinds; the pair may come in either order.
//   rsp channel returns one item per pair: hit flag and x/y overlap.
// Stages and throughput:
//   Four register stages (ordering/ends, axis overlap, squaring, compare).
//   A result is registered in the compare stage and shows on rsp from there;
//   one item per cycle is taken and returned when rsp is not stalled.
// Reset:
//   Synchronous; empties all stages, nothing is held over.
// Stalls:
//   With rsp_tready low the result holds; earlier stages keep filling
//   until all four are full, and only then does req_tready fall.
// ----------------------------------------------------------------------------
module shape_pair_collision_overlap #(
   parameter int COORD_BITS = spcol_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // a_x, a_y, a_width, a_height, a_radius, b_x, b_y, b_width, b_height,
   // b_radius, zero fill
   input  logic [((10*COORD_BITS+7)/8)*8-1:0]    req_tdata,
   // a_is_circle, b_is_circle
   input  logic [1:0]                            req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // hit, overlap_x, overlap_y, zero fill
   output logic [((2*COORD_BITS+10)/8)*8-1:0]    rsp_tdata
);

   localparam int N      = COORD_BITS;
   localparam int RSP_DW = ((2*COORD_BITS+10)/8)*8;

   logic                 a_is_circle;
   logic signed [N-1:0]  a_x;
   logic signed [N-1:0]  a_y;
   logic        [N-1:0]  a_width;
   logic        [N-1:0]  a_height;
   logic        [N-1:0]  a_radius;
   logic                 b_is_circle;
   logic signed [N-1:0]  b_x;
   logic signed [N-1:0]  b_y;
   logic        [N-1:0]  b_width;
   logic        [N-1:0]  b_height;
   logic        [N-1:0]  b_radius;

   logic                 s1_valid;
   logic                 s1_ready;
   logic [1:0]           s1_mode;
   logic signed [N+1:0]  s1_p_lo [2];
   logic signed [N+1:0]  s1_p_hi [2];
   logic signed [N+1:0]  s1_q_lo [2];
   logic signed [N+1:0]  s1_q_hi [2];
   logic signed [N-1:0]  s1_p_ctr [2];
   logic signed [N-1:0]  s1_q_ctr [2];
   logic [N:0]           s1_lim;

   logic                 s2_valid;
   logic                 s2_ready;
   logic [1:0]           s2_mode;
   logic [1:0]           s2_axis_hit;
   logic [N:0]           s2_ovl [2];
   logic [N-1:0]         s2_mag [2];
   logic [N:0]           s2_lim;

   logic                 hit;
   logic [N:0]           overlap_x;
   logic [N:0]           overlap_y;

   assign a_is_circle = req_tuser[0];
   assign b_is_circle = req_tuser[1];
   assign a_x         = req_tdata[0*N +: N];
   assign a_y         = req_tdata[1*N +: N];
   assign a_width     = req_tdata[2*N +: N];
   assign a_height    = req_tdata[3*N +: N];
   assign a_radius    = req_tdata[4*N +: N];
   assign b_x         = req_tdata[5*N +: N];
   assign b_y         = req_tdata[6*N +: N];
   assign b_width     = req_tdata[7*N +: N];
   assign b_height    = req_tdata[8*N +: N];
   assign b_radius    = req_tdata[9*N +: N];

   spcol_prep #(.COORD_BITS(COORD_BITS)) u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .a_is_circle (a_is_circle),
      .a_x         (a_x),
      .a_y         (a_y),
      .a_width     (a_width),
      .a_height    (a_height),
      .a_radius    (a_radius),
      .b_is_circle (b_is_circle),
      .b_x         (b_x),
      .b_y         (b_y),
      .b_width     (b_width),
      .b_height    (b_height),
      .b_radius    (b_radius),
      .out_valid   (s1_valid),
      .out_ready   (s1_ready),
      .mode        (s1_mode),
      .p_lo        (s1_p_lo),
      .p_hi        (s1_p_hi),
      .q_lo        (s1_q_lo),
      .q_hi        (s1_q_hi),
      .p_ctr       (s1_p_ctr),
      .q_ctr       (s1_q_ctr),
      .lim         (s1_lim)
   );

   spcol_span #(.COORD_BITS(COORD_BITS)) u_span (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .mode      (s1_mode),
      .p_lo      (s1_p_lo),
      .p_hi      (s1_p_hi),
      .q_lo      (s1_q_lo),
      .q_hi      (s1_q_hi),
      .p_ctr     (s1_p_ctr),
      .q_ctr     (s1_q_ctr),
      .lim       (s1_lim),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .mode_out  (s2_mode),
      .axis_hit  (s2_axis_hit),
      .ovl       (s2_ovl),
      .mag       (s2_mag),
      .lim_out   (s2_lim)
   );

   spcol_judge #(.COORD_BITS(COORD_BITS)) u_judge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .mode      (s2_mode),
      .axis_hit  (s2_axis_hit),
      .ovl       (s2_ovl),
      .mag       (s2_mag),
      .lim       (s2_lim),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .hit       (hit),
      .overlap_x (overlap_x),
      .overlap_y (overlap_y)
   );

   assign rsp_tdata = RSP_DW'({overlap_y, overlap_x, hit});

endmodule

// File: design/spcol_prep.sv
// ----------------------------------------------------------------------------
// spcol_prep: pair ordering and interval ends
// Puts a rectangle first in a mixed pair, forms the interval ends of both
// shapes on each axis and the distance limit, then registers them.
// ----------------------------------------------------------------------------
module spcol_prep #(
   parameter int COORD_BITS = spcol_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic                         a_is_circle,
   input  logic signed [COORD_BITS-1:0] a_x,
   input  logic signed [COORD_BITS-1:0] a_y,
   input  logic        [COORD_BITS-1:0] a_width,
   input  logic        [COORD_BITS-1:0] a_height,
   input  logic        [COORD_BITS-1:0] a_radius,
   input  logic                         b_is_circle,
   input  logic signed [COORD_BITS-1:0] b_x,
   input  logic signed [COORD_BITS-1:0] b_y,
   input  logic        [COORD_BITS-1:0] b_width,
   input  logic        [COORD_BITS-1:0] b_height,
   input  logic        [COORD_BITS-1:0] b_radius,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [1:0]                   mode,
   output logic signed [COORD_BITS+1:0] p_lo [2],
   output logic signed [COORD_BITS+1:0] p_hi [2],
   output logic signed [COORD_BITS+1:0] q_lo [2],
   output logic signed [COORD_BITS+1:0] q_hi [2],
   output logic signed [COORD_BITS-1:0] p_ctr [2],
   output logic signed [COORD_BITS-1:0] q_ctr [2],
   output logic        [COORD_BITS:0]   lim
);

   localparam int W  = COORD_BITS + 2;
   localparam int LW = COORD_BITS + 1;

   logic                         swap;
   logic                         p_circ;
   logic                         q_circ;
   logic        [COORD_BITS-1:0] p_r;
   logic        [COORD_BITS-1:0] q_r;
   logic        [COORD_BITS-1:0] p_sz [2];
   logic        [COORD_BITS-1:0] q_sz [2];
   logic signed [COORD_BITS-1:0] p_c  [2];
   logic signed [COORD_BITS-1:0] q_c  [2];

   logic                         valid_ff;
   logic                         valid_in;
   logic [1:0]                   mode_ff;
   logic [1:0]                   mode_in;
   logic signed [W-1:0]          p_lo_ff [2];
   logic signed [W-1:0]          p_lo_in [2];
   logic signed [W-1:0]          p_hi_ff [2];
   logic signed [W-1:0]          p_hi_in [2];
   logic signed [W-1:0]          q_lo_ff [2];
   logic signed [W-1:0]          q_lo_in [2];
   logic signed [W-1:0]          q_hi_ff [2];
   logic signed [W-1:0]          q_hi_in [2];
   logic signed [COORD_BITS-1:0] p_ctr_ff [2];
   logic signed [COORD_BITS-1:0] q_ctr_ff [2];
   logic [LW-1:0]                lim_ff;
   logic [LW-1:0]                lim_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      swap    = a_is_circle && !b_is_circle;
      p_circ  = swap ? b_is_circle : a_is_circle;
      q_circ  = swap ? a_is_circle : b_is_circle;
      p_r     = swap ? b_radius : a_radius;
      q_r     = swap ? a_radius : b_radius;
      p_c[0]  = swap ? b_x : a_x;
      p_c[1]  = swap ? b_y : a_y;
      q_c[0]  = swap ? a_x : b_x;
      q_c[1]  = swap ? a_y : b_y;
      p_sz[0] = swap ? b_width : a_width;
      p_sz[1] = swap ? b_height : a_height;
      q_sz[0] = swap ? a_width : b_width;
      q_sz[1] = swap ? a_height : b_height;

      if (!p_circ && !q_circ) begin
         mode_in = spcol_pkg::MODE_RR;
      end else if (!p_circ) begin
         mode_in = spcol_pkg::MODE_RC;
      end else begin
         mode_in = spcol_pkg::MODE_CC;
      end

      for (int k = 0; k < 2; k++) begin
         p_lo_in[k] = W'(p_c[k]) - (p_circ ? W'(p_r) : W'(0));
         p_hi_in[k] = W'(p_c[k]) + (p_circ ? W'(p_r) : W'(p_sz[k]));
         q_lo_in[k] = W'(q_c[k]) - (q_circ ? W'(q_r) : W'(0));
         q_hi_in[k] = W'(q_c[k]) + (q_circ ? W'(q_r) : W'(q_sz[k]));
      end

      if (mode_in == spcol_pkg::MODE_CC) begin
         lim_in = LW'(p_r) + LW'(q_r);
      end else begin
         lim_in = LW'(q_r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mode_ff <= mode_in;
         lim_ff  <= lim_in;
         for (int k = 0; k < 2; k++) begin
            p_lo_ff[k]  <= p_lo_in[k];
            p_hi_ff[k]  <= p_hi_in[k];
            q_lo_ff[k]  <= q_lo_in[k];
            q_hi_ff[k]  <= q_hi_in[k];
            p_ctr_ff[k] <= p_c[k];
            q_ctr_ff[k] <= q_c[k];
         end
      end
   end

   assign out_valid = valid_ff;
   assign mode      = mode_ff;
   assign lim       = lim_ff;
   assign p_lo      = p_lo_ff;
   assign p_hi      = p_hi_ff;
   assign q_lo      = q_lo_ff;
   assign q_hi      = q_hi_ff;
   assign p_ctr     = p_ctr_ff;
   assign q_ctr     = q_ctr_ff;

endmodule

// File: design/spcol_span.sv
// ----------------------------------------------------------------------------
// spcol_span: per-axis overlap and distance component
// Computes the overlap on each axis and the magnitude of the axis distance
// that feeds the squared-distance test, then registers them.
// ----------------------------------------------------------------------------
module spcol_span #(
   parameter int COORD_BITS = spcol_pkg::COORD_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [1:0]                   mode,
   input  logic signed [COORD_BITS+1:0] p_lo [2],
   input  logic signed [COORD_BITS+1:0] p_hi [2],
   input  logic signed [COORD_BITS+1:0] q_lo [2],
   input  logic signed [COORD_BITS+1:0] q_hi [2],
   input  logic signed [COORD_BITS-1:0] p_ctr [2],
   input  logic signed [COORD_BITS-1:0] q_ctr [2],
   input  logic        [COORD_BITS:0]   lim,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [1:0]                   mode_out,
   output logic [1:0]                   axis_hit,
   output logic [COORD_BITS:0]          ovl [2],
   output logic [COORD_BITS-1:0]        mag [2],
   output logic [COORD_BITS:0]          lim_out
);

   localparam int W  = COORD_BITS + 2;
   localparam int LW = COORD_BITS + 1;

   logic signed [W-1:0]          sp_lo  [2];
   logic signed [W-1:0]          sp_hi  [2];
   logic signed [W-1:0]          sp_len [2];
   logic [LW-1:0]                sp_ov  [2];
   logic signed [LW-1:0]         cd     [2];
   logic signed [LW-1:0]         cd_abs [2];
   logic [LW-1:0]                cd_mag [2];
   logic [LW-1:0]                cc_ov  [2];
   logic signed [W-1:0]          q_ext  [2];
   logic signed [W-1:0]          rd     [2];
   logic signed [W-1:0]          rd_abs [2];

   logic                         valid_ff;
   logic                         valid_in;
   logic [1:0]                   mode_ff;
   logic [1:0]                   axis_hit_ff;
   logic [1:0]                   axis_hit_in;
   logic [LW-1:0]                lim_ff;
   logic [LW-1:0]                ovl_ff [2];
   logic [LW-1:0]                ovl_in [2];
   logic [COORD_BITS-1:0]        mag_ff [2];
   logic [COORD_BITS-1:0]        mag_in [2];

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_comb begin
      for (int k = 0; k < 2; k++) begin
         sp_lo[k]  = (p_lo[k] > q_lo[k]) ? p_lo[k] : q_lo[k];
         sp_hi[k]  = (p_hi[k] < q_hi[k]) ? p_hi[k] : q_hi[k];
         sp_len[k] = sp_hi[k] - sp_lo[k];
         // open intervals overlap; a zero-length one can still sit inside
         axis_hit_in[k] = (p_lo[k] < q_hi[k]) && (p_hi[k] > q_lo[k]);
         if (axis_hit_in[k]) begin
            sp_ov[k] = sp_len[k][LW-1:0];
         end else begin
            sp_ov[k] = '0;
         end

         cd[k]     = LW'(p_ctr[k]) - LW'(q_ctr[k]);
         cd_abs[k] = cd[k][LW-1] ? -cd[k] : cd[k];
         cd_mag[k] = cd_abs[k];
         cc_ov[k]  = (cd_mag[k] < lim) ? (lim - cd_mag[k]) : '0;

         // circle center minus its clamp into the rectangle
         q_ext[k] = W'(q_ctr[k]);
         if (q_ext[k] < p_lo[k]) begin
            rd[k] = q_ext[k] - p_lo[k];
         end else if (q_ext[k] > p_hi[k]) begin
            rd[k] = q_ext[k] - p_hi[k];
         end else begin
            rd[k] = '0;
         end
         rd_abs[k] = rd[k][W-1] ? -rd[k] : rd[k];

         if (mode == spcol_pkg::MODE_CC) begin
            ovl_in[k] = cc_ov[k];
            mag_in[k] = cd_mag[k][COORD_BITS-1:0];
         end else begin
            ovl_in[k] = sp_ov[k];
            mag_in[k] = rd_abs[k][COORD_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         mode_ff     <= mode;
         axis_hit_ff <= axis_hit_in;
         lim_ff      <= lim;
         for (int k = 0; k < 2; k++) begin
            ovl_ff[k] <= ovl_in[k];
            mag_ff[k] <= mag_in[k];
         end
      end
   end

   assign out_valid = valid_ff;
   assign mode_out  = mode_ff;
   assign axis_hit  = axis_hit_ff;
   assign lim_out   = lim_ff;
   assign ovl       = ovl_ff;
   assign mag       = mag_ff;

endmodule

// File: design/spcol_judge.sv
// ----------------------------------------------------------------------------
// spcol_judge: squared distance test and result register
// One stage squares the axis distances and the limit, the next sums and
// compares them and holds the result item for the rsp channel.
// ----------------------------------------------------------------------------
module spcol_judge #(
   parameter int COORD_BITS = spcol_pkg::COORD_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [1:0]            mode,
   input  logic [1:0]            axis_hit,
   input  logic [COORD_BITS:0]   ovl [2],
   input  logic [COORD_BITS-1:0] mag [2],
   input  logic [COORD_BITS:0]   lim,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  hit,
   output logic [COORD_BITS:0]   overlap_x,
   output logic [COORD_BITS:0]   overlap_y
);

   localparam int LW  = COORD_BITS + 1;
   localparam int SQW = 2 * COORD_BITS;
   localparam int LQW = 2 * COORD_BITS + 2;

   logic            sq_valid_ff;
   logic            sq_valid_in;
   logic            sq_ready;
   logic [1:0]      sq_mode_ff;
   logic [1:0]      sq_axis_hit_ff;
   logic [LW-1:0]   sq_ovl_ff [2];
   logic [SQW-1:0]  sq_x_ff;
   logic [SQW-1:0]  sq_x_in;
   logic [SQW-1:0]  sq_y_ff;
   logic [SQW-1:0]  sq_y_in;
   logic [LQW-1:0]  sq_l_ff;
   logic [LQW-1:0]  sq_l_in;

   logic            res_valid_ff;
   logic            res_valid_in;
   logic            res_ready;
   logic            hit_ff;
   logic            hit_in;
   logic [LW-1:0]   ovx_ff;
   logic [LW-1:0]   ovy_ff;
   logic [SQW:0]    dist_sum;
   logic            dist_hit;

   assign res_ready    = !res_valid_ff || out_ready;
   assign sq_ready     = !sq_valid_ff || res_ready;
   assign in_ready     = sq_ready;
   assign sq_valid_in  = sq_ready ? in_valid : sq_valid_ff;
   assign res_valid_in = res_ready ? sq_valid_ff : res_valid_ff;

   assign sq_x_in = SQW'(mag[0]) * SQW'(mag[0]);
   assign sq_y_in = SQW'(mag[1]) * SQW'(mag[1]);
   assign sq_l_in = LQW'(lim) * LQW'(lim);

   always_comb begin
      dist_sum = (SQW+1)'(sq_x_ff) + (SQW+1)'(sq_y_ff);
      dist_hit = LQW'(dist_sum) < sq_l_ff;
      if (sq_mode_ff == spcol_pkg::MODE_RR) begin
         hit_in = &sq_axis_hit_ff;
      end else begin
         hit_in = dist_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         res_valid_ff <= 1'b0;
      end else begin
         sq_valid_ff  <= sq_valid_in;
         res_valid_ff <= res_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && sq_ready) begin
         sq_mode_ff     <= mode;
         sq_axis_hit_ff <= axis_hit;
         sq_ovl_ff[0]   <= ovl[0];
         sq_ovl_ff[1]   <= ovl[1];
         sq_x_ff        <= sq_x_in;
         sq_y_ff        <= sq_y_in;
         sq_l_ff        <= sq_l_in;
      end
   end

   always_ff @(posedge clock) begin
      if (sq_valid_ff && res_ready) begin
         hit_ff <= hit_in;
         ovx_ff <= sq_ovl_ff[0];
         ovy_ff <= sq_ovl_ff[1];
      end
   end

   assign out_valid = res_valid_ff;
   assign hit       = hit_ff;
   assign overlap_x = ovx_ff;
   assign overlap_y = ovy_ff;

endmodule

// File: design/spcol_checker.sv
// ----------------------------------------------------------------------------
// spcol_checker: port-level checks for the shape pair collision block
// Tracks items in flight and checks stall and backpressure behavior.
// ----------------------------------------------------------------------------
module spcol_checker #(
   parameter int COORD_BITS = spcol_pkg::COORD_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [((2*COORD_BITS+10)/8)*8-1:0] rsp_tdata
);

   localparam int CW = $clog2(spcol_pkg::PIPE_DEPTH + 2);

   logic          req_fire;
   logic          rsp_fire;
   logic [CW-1:0] inflight_ff;
   logic [CW-1:0] inflight_in;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_fire && !rsp_fire) begin
         inflight_in = inflight_ff + CW'(1);
      end else if (!req_fire && rsp_fire) begin
         inflight_in = inflight_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp item changed while stalled");

   a_inflight_bound: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= CW'(spcol_pkg::PIPE_DEPTH))
      else $error("more items in flight than pipeline stages");

   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> inflight_ff != '0)
      else $error("rsp item with no item accepted");

   a_backpressure_only: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled while rsp side is free");

endmodule

bind shape_pair_collision_overlap spcol_checker #(.COORD_BITS(COORD_BITS)) u_spcol_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
